>>> hdl/d2h_pkg.sv
// ----------------------------------------------------------------------------
// d2h_pkg: shared types and constants of the disparity colorizer
// Widths of the hue datapath, divider staging and register indexes.
// ----------------------------------------------------------------------------
package d2h_pkg;

  // Field widths
  localparam int unsigned DISP_W = 8;
  localparam int unsigned SV_W   = 9;   // saturation / value, Q1.8
  localparam int unsigned CH_W   = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL      = 2'd2;

  // Hue division: (max - d) * 240 / max, quotient never above 240
  localparam int unsigned HUE_SPAN       = 240;
  localparam int unsigned NUM_W          = 16;
  localparam int unsigned QUOT_W         = 8;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / BITS_PER_STAGE;

  // Sector / fraction
  localparam int unsigned SEC_W  = 3;
  localparam int unsigned REM_W  = 6;
  localparam int unsigned F16_W  = 16;

  // Q.24 factors and Q.32 products
  localparam int unsigned K_W = 26;
  localparam int unsigned X_W = 35;

  // Divider result handed to the sector stage
  typedef struct packed {
    logic              vld;
    logic [QUOT_W-1:0] quot;
  } div_out_t;

endpackage

>>> hdl/d2h_div.sv
// ----------------------------------------------------------------------------
// d2h_div: pipelined restoring divider for the hue, two quotient bits per stage
// The user must keep the divisor static while items are in flight; not checked.
// ----------------------------------------------------------------------------
module d2h_div
  import d2h_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DISP_W-1:0]     den_i,
  output div_out_t              res_o
);

  logic              vld_q [DIV_STAGES];
  logic [QUOT_W-1:0] quo_q [DIV_STAGES];
  logic [NUM_W-1:0]  rem_q [DIV_STAGES-1];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic              vld_in;
    logic [QUOT_W-1:0] quo_in;
    logic [NUM_W-1:0]  rem_in;
    logic [QUOT_W-1:0] quo_nx;
    logic [NUM_W-1:0]  rem_nx;

    if (g == 0) begin : g_first
      assign vld_in = in_vld_i;
      assign quo_in = '0;
      assign rem_in = num_i;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign quo_in = quo_q[g-1];
      assign rem_in = rem_q[g-1];
    end

    // two compare-subtract steps
    always_comb begin
      logic [NUM_W-1:0] trial;
      rem_nx = rem_in;
      quo_nx = quo_in;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        trial = NUM_W'(den_i) << (QUOT_W - 1 - g * BITS_PER_STAGE - b);
        if (rem_nx >= trial) begin
          rem_nx = rem_nx - trial;
          quo_nx[QUOT_W - 1 - g * BITS_PER_STAGE - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[g] <= quo_nx;
    end

    // the last stage leaves its remainder behind
    if (g < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[g] <= rem_nx;
      end
    end
  end

  assign res_o.vld  = vld_q[DIV_STAGES-1];
  assign res_o.quot = quo_q[DIV_STAGES-1];

endmodule

>>> hdl/disparity_to_hue_colorizer_core.sv
// ----------------------------------------------------------------------------
// disparity_to_hue_colorizer_core: disparity pixel to BGR via HSV hue map
// Clamps the pixel, divides for the hue, forms p/q/t and scales to 8 bits.
// ----------------------------------------------------------------------------
// One pixel per clock: a pixel is taken on every cycle with start high, and
// busy never rises. Each result appears on blue_o/green_o/red_o for one
// cycle with done_o high; results come out in order and cannot be held off.
// Each pixel runs through the clamp and numerator stage, the hue divider
// (four stages of two quotient bits each), the sector split, the fraction,
// the saturation products, the value products and the output clamp. The
// configuration registers must only be written while no pixel is in flight.
module disparity_to_hue_colorizer_core
  import d2h_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SV_W-1:0]      cfg_data_i,
  input  logic [DISP_W-1:0]    disparity_i,
  output logic                 done_o,
  output logic [CH_W-1:0]      blue_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      red_o
);

  localparam int unsigned Latency = 10;
  localparam logic [K_W-1:0] OneQ24 = K_W'(1) << 24;
  localparam logic [F16_W:0] OneQ16 = (F16_W+1)'(1) << 16;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [DISP_W-1:0] max_q;
  logic [SV_W-1:0]   sat_q;
  logic [SV_W-1:0]   val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= DISP_W'(255);
      sat_q <= SV_W'(256);
      val_q <= SV_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_DISP: max_q <= cfg_data_i[DISP_W-1:0];
        CFG_SAT:      sat_q <= cfg_data_i;
        CFG_VAL:      val_q <= cfg_data_i;
        default:      ;  // index beyond the list: ignored
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: clamp pixel, numerator (max - d) * 240
  logic [DISP_W-1:0] d_clamp;
  logic [DISP_W-1:0] diff;
  logic [NUM_W-1:0]  num_d;
  logic [NUM_W-1:0]  num_q;
  logic              num_vld_q;

  always_comb begin
    d_clamp = (disparity_i > max_q) ? max_q : disparity_i;
    diff    = max_q - d_clamp;
    num_d   = NUM_W'(diff) * NUM_W'(HUE_SPAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
    end else begin
      num_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  // ---------------------------------------------------------------------------
  // Stages 2..5: hue = numerator / max
  div_out_t hue;

  d2h_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (num_vld_q),
    .num_i    (num_q),
    .den_i    (max_q),
    .res_o    (hue)
  );

  // ---------------------------------------------------------------------------
  // Stage 6: sector = hue / 60, remainder = hue mod 60
  logic [SEC_W-1:0] sec_d;
  logic [QUOT_W-1:0] rem_full;
  logic [SEC_W-1:0] sec_q;
  logic [REM_W-1:0] rem_q;
  logic             sec_vld_q;

  always_comb begin
    priority if (hue.quot >= QUOT_W'(240)) begin
      sec_d    = SEC_W'(4);
      rem_full = hue.quot - QUOT_W'(240);
    end else if (hue.quot >= QUOT_W'(180)) begin
      sec_d    = SEC_W'(3);
      rem_full = hue.quot - QUOT_W'(180);
    end else if (hue.quot >= QUOT_W'(120)) begin
      sec_d    = SEC_W'(2);
      rem_full = hue.quot - QUOT_W'(120);
    end else if (hue.quot >= QUOT_W'(60)) begin
      sec_d    = SEC_W'(1);
      rem_full = hue.quot - QUOT_W'(60);
    end else begin
      sec_d    = SEC_W'(0);
      rem_full = hue.quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_vld_q <= 1'b0;
    end else begin
      sec_vld_q <= hue.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q <= sec_d;
    rem_q <= rem_full[REM_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 7: f16 = floor(rem * 65536 / 60) = rem*1092 + floor(rem*4/15)
  // floor(a/15) for a < 240 is exact as (a*137) >> 11
  logic [F16_W-1:0] frac_d;
  logic [F16_W-1:0] frac_corr;
  logic [F16_W-1:0] frac_q;
  logic [SEC_W-1:0] frac_sec_q;
  logic             frac_vld_q;

  always_comb begin
    frac_corr = (F16_W'(rem_q) * F16_W'(548)) >> 11;
    frac_d    = F16_W'(rem_q) * F16_W'(1092) + frac_corr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_vld_q <= 1'b0;
    end else begin
      frac_vld_q <= sec_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q     <= frac_d;
    frac_sec_q <= sec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: Q.24 factors 1 - f*S, 1 - (1-f)*S, 1 - S
  logic [K_W-1:0]        prod_q_fac;
  logic [K_W-1:0]        prod_t_fac;
  logic [K_W-1:0]        prod_p_fac;
  logic signed [K_W-1:0] kq_q, kt_q, kp_q;
  logic [SEC_W-1:0]      k_sec_q;
  logic                  k_vld_q;

  always_comb begin
    prod_q_fac = K_W'(frac_q) * K_W'(sat_q);
    prod_t_fac = K_W'(OneQ16 - (F16_W+1)'(frac_q)) * K_W'(sat_q);
    prod_p_fac = K_W'(sat_q) << 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_vld_q <= 1'b0;
    end else begin
      k_vld_q <= frac_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kq_q    <= signed'(OneQ24 - prod_q_fac);
    kt_q    <= signed'(OneQ24 - prod_t_fac);
    kp_q    <= signed'(OneQ24 - prod_p_fac);
    k_sec_q <= frac_sec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 9: Q.32 values V*factor
  logic signed [X_W-1:0] v_s;
  logic signed [X_W-1:0] xq_q, xt_q, xp_q, xv_q;
  logic [SEC_W-1:0]      x_sec_q;
  logic                  x_vld_q;

  assign v_s = X_W'(val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= 1'b0;
    end else begin
      x_vld_q <= k_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xq_q    <= X_W'(kq_q) * v_s;
    xt_q    <= X_W'(kt_q) * v_s;
    xp_q    <= X_W'(kp_q) * v_s;
    xv_q    <= v_s <<< 24;
    x_sec_q <= k_sec_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 10: sector select, clamp to 0..1, scale by 255
  function automatic logic [CH_W-1:0] to_channel(input logic signed [X_W-1:0] x);
    logic [32:0] c;
    logic [40:0] scaled;
    if (x < 0) begin
      c = '0;
    end else if (x > X_W'(64'h1_0000_0000)) begin
      c = 33'h1_0000_0000;
    end else begin
      c = x[32:0];
    end
    scaled = {c, 8'b0} - 41'(c);
    return scaled[39:32];
  endfunction

  logic signed [X_W-1:0] b_x, g_x, r_x;
  logic [CH_W-1:0]       blue_d, green_d, red_d;
  logic                  done_q;
  logic [CH_W-1:0]       blue_q, green_q, red_q;

  always_comb begin
    unique case (x_sec_q)
      SEC_W'(0): begin b_x = xp_q; g_x = xt_q; r_x = xv_q; end
      SEC_W'(1): begin b_x = xp_q; g_x = xv_q; r_x = xq_q; end
      SEC_W'(2): begin b_x = xt_q; g_x = xv_q; r_x = xp_q; end
      SEC_W'(3): begin b_x = xv_q; g_x = xq_q; r_x = xp_q; end
      SEC_W'(4): begin b_x = xv_q; g_x = xp_q; r_x = xt_q; end
      default:   begin b_x = xq_q; g_x = xp_q; r_x = xv_q; end
    endcase
    // zero maximum: black
    if (max_q == '0) begin
      blue_d  = '0;
      green_d = '0;
      red_d   = '0;
    end else begin
      blue_d  = to_channel(b_x);
      green_d = to_channel(g_x);
      red_d   = to_channel(r_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= x_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    blue_q  <= blue_d;
    green_q <= green_d;
    red_q   <= red_d;
  end

  assign done_o  = done_q;
  assign blue_o  = blue_q;
  assign green_o = green_q;
  assign red_o   = red_q;

  // ---------------------------------------------------------------------------
  // Assertions

  // every transfer in gives exactly one result strobe, and no strobe comes without one
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, Latency) |-> (done_o == $past(accept, Latency)))
    else $error("result strobe does not match accepted pixel");

  // sector split keeps the sector at most 4 and the remainder below one sector
  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> (sec_q <= SEC_W'(4)) && (rem_q < REM_W'(60)))
    else $error("sector or remainder out of range");

  // zero maximum gives black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_vld_q && max_q == '0) |=> (blue_o == '0) && (green_o == '0) && (red_o == '0))
    else $error("zero maximum did not give black");

endmodule
